FILE: rtl/lmsalp_pkg.sv
// Shared widths, codes and saturation helpers for the LMS adaptive linear predictor.
`default_nettype none

package lmsalp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 16;
    localparam int COEF_W     = 32;
    localparam int IDX_W      = 6;
    localparam int ACC_SHIFT  = 27;
    localparam int UPD_SHIFT  = 18;
    localparam int MU_ERR_W   = STEP_W + SAMPLE_W + 1;
    localparam int PROD_W     = MU_ERR_W + SAMPLE_W;
    localparam int OUT_DATA_W = 72;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd3277;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [MU_ERR_W-1:0] t_mu_err;
    typedef logic signed [PROD_W-1:0]   t_prod;

    typedef enum logic {
        KIND_PRED = 1'b0,
        KIND_COEF = 1'b1
    } t_kind;

    // Negate a coefficient, clamping the most negative value to the largest positive one
    function automatic t_coef neg_sat(input t_coef w);
        t_coef r;
        if (w == {1'b1, {(COEF_W-1){1'b0}}}) begin
            r = {1'b0, {(COEF_W-1){1'b1}}};
        end else begin
            r = -w;
        end
        return r;
    endfunction

    // Add the scaled update term to a coefficient and clamp to 32 bits
    function automatic t_coef upd_sat(input t_coef w, input t_prod d);
        logic signed [PROD_W-UPD_SHIFT-1:0] d_sh;
        logic signed [COEF_W:0]             s;
        t_coef                              r;
        d_sh = d[PROD_W-1:UPD_SHIFT];
        s    = {w[COEF_W-1], w} + (COEF_W+1)'(d_sh);
        if (s[COEF_W] != s[COEF_W-1]) begin
            r = s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end else begin
            r = s[COEF_W-1:0];
        end
        return r;
    endfunction

    // Clamp a 17-bit difference to 16 bits
    function automatic t_sample sat17(input logic signed [SAMPLE_W:0] v);
        t_sample r;
        if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
            r = v[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lms_adaptive_linear_predictor_top.sv
// LMS adaptive linear predictor: coefficient and history memories with a shared MAC.
//
// Input beats on s_axis carry one Q1.15 sample; s_axis_tlast asks for a coefficient
// dump after that sample. Each sample gives one result beat on m_axis (tuser = 0)
// with the saturated prediction and error; with a dump request TAPS more beats
// follow (tuser = 1) holding the negated Q5.27 coefficients 1..TAPS, and tlast
// marks the final beat caused by the input. The step size is written on the cfg
// channel, which is always ready; the user must write it only while the block is
// idle, as the block itself does not enforce this. An item runs a prediction
// pass and an update pass, each with one memory read and one multiply per tap,
// with steps to form the error, load the result and take the next input beat;
// a dump then takes one memory read per beat.
// Reset is synchronous: afterwards a clearing pass writes zero to every entry of
// both memories, during which s_axis_tready stays low.
// A single output register holds each result; while the receiver stalls the
// block finishes its update and waits at the next result, and a new input beat
// may be taken while the last result of the previous one still waits.
`default_nettype none

module lms_adaptive_linear_predictor_top
    import lmsalp_pkg::*;
#(
    parameter int TAPS = 10
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input beats
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [15:0]           s_axis_tdata,   // [15:0] sample
    input  wire                   s_axis_tlast,   // frame_end
    // result beats
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] prediction, [31:16] error,
                                                  // [37:32] coef_index, [69:38] coefficient
    output logic                  m_axis_tuser,   // kind
    output logic                  m_axis_tlast,   // last
    // step size register
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [STEP_W-1:0]     i_cfg_data
);

    localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW = $clog2(TAPS + 1);
    localparam int AW = PROD_W + $clog2(TAPS + 1);
    localparam int SW = AW - ACC_SHIFT;
    localparam logic signed [SW-1:0] PRED_MAX = SW'(32767);
    localparam logic signed [SW-1:0] PRED_MIN = -SW'(32768);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_PRED,
        S_CALC,
        S_EMIT,
        S_UPD,
        S_DUMP_RD,
        S_DUMP_WR
    } t_state;

    // memories
    t_coef   w_mem [TAPS];
    t_sample h_mem [TAPS];

    // control registers
    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [IW-1:0]     r_head, n_head;
    logic              r_rd_vld, r_p_vld;
    logic              r_out_vld, n_out_vld;
    logic [STEP_W-1:0] r_step;

    // datapath registers
    t_sample           r_x;
    logic              r_fend;
    t_coef             r_wrd;
    t_sample           r_hrd;
    t_prod             r_prod;
    t_coef             r_wold;
    logic [IW-1:0]     r_addr1, r_addr2;
    logic signed [AW-1:0] r_acc;
    t_sample           r_pred, r_err;
    t_mu_err           r_mu_err;
    t_sample           r_o_pred, r_o_err;
    logic [IDX_W-1:0]  r_o_idx;
    t_coef             r_o_coef;
    t_kind             r_o_kind;
    logic              r_o_last;

    // combinational control
    logic              s_acc;
    logic              out_free, out_load_pred, out_load_coef;
    logic              pipe_issue, rd_en, acc_clr;
    logic [IW-1:0]     w_raddr, h_raddr;
    logic              w_we, h_we;
    logic [IW-1:0]     w_waddr, h_waddr;
    t_coef             w_wdata;
    t_sample           h_wdata;
    logic [IW:0]       circ_sum;
    logic [IW-1:0]     head_new;
    t_mu_err           mul_a;
    t_prod             mul_p;
    logic signed [SW-1:0] acc_sh;
    t_sample           pred_c;
    t_sample           err_c;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    // history entry i lives at (head + i) mod TAPS
    assign circ_sum = {1'b0, r_head} + {1'b0, r_cnt[IW-1:0]};
    assign h_raddr  = (circ_sum >= (IW+1)'(TAPS)) ? IW'(circ_sum - (IW+1)'(TAPS))
                                                  : circ_sum[IW-1:0];
    assign head_new = (r_head == '0) ? IW'(TAPS - 1) : r_head - IW'(1);
    assign w_raddr  = r_cnt[IW-1:0];

    // shared multiplier: weight times history, or mu*error times history
    assign mul_a = (r_state == S_UPD) ? r_mu_err : MU_ERR_W'(r_wrd);
    assign mul_p = PROD_W'(mul_a) * PROD_W'(r_hrd);

    // prediction and error from the accumulated dot product
    assign acc_sh = SW'(r_acc >>> ACC_SHIFT);
    always_comb begin
        if (acc_sh > PRED_MAX) begin
            pred_c = 16'sh7fff;
        end else if (acc_sh < PRED_MIN) begin
            pred_c = 16'sh8000;
        end else begin
            pred_c = acc_sh[SAMPLE_W-1:0];
        end
        err_c = sat17({r_x[SAMPLE_W-1], r_x} - {pred_c[SAMPLE_W-1], pred_c});
    end

    // sequencer decode
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_head        = r_head;
        pipe_issue    = 1'b0;
        rd_en         = 1'b0;
        acc_clr       = 1'b0;
        out_load_pred = 1'b0;
        out_load_coef = 1'b0;
        w_we          = 1'b0;
        w_waddr       = r_addr2;
        w_wdata       = upd_sat(r_wold, r_prod);
        h_we          = 1'b0;
        h_waddr       = head_new;
        h_wdata       = r_x;
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                h_we    = 1'b1;
                w_waddr = r_cnt[IW-1:0];
                h_waddr = r_cnt[IW-1:0];
                w_wdata = '0;
                h_wdata = '0;
                if (r_cnt == CW'(TAPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    acc_clr = 1'b1;
                    n_cnt   = '0;
                    n_state = S_PRED;
                end
            end
            S_PRED: begin
                if (r_cnt < CW'(TAPS)) begin
                    pipe_issue = 1'b1;
                    n_cnt      = r_cnt + CW'(1);
                end else if (!r_rd_vld && !r_p_vld) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load_pred = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                w_we = r_p_vld;
                if (r_cnt < CW'(TAPS)) begin
                    pipe_issue = 1'b1;
                    n_cnt      = r_cnt + CW'(1);
                end else if (!r_rd_vld && !r_p_vld) begin
                    // shift the history by moving the head and storing the new sample
                    h_we    = 1'b1;
                    n_head  = head_new;
                    n_cnt   = '0;
                    n_state = r_fend ? S_DUMP_RD : S_IDLE;
                end
            end
            S_DUMP_RD: begin
                if (out_free) begin
                    rd_en   = 1'b1;
                    n_state = S_DUMP_WR;
                end
            end
            S_DUMP_WR: begin
                out_load_coef = 1'b1;
                if (r_cnt == CW'(TAPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_DUMP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (pipe_issue) begin
            rd_en = 1'b1;
        end
    end

    // output valid: load takes priority over a drain
    always_comb begin
        n_out_vld = r_out_vld;
        if (out_load_pred || out_load_coef) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    // control state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_head    <= '0;
            r_rd_vld  <= 1'b0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_step    <= STEP_RESET;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_head    <= n_head;
            r_rd_vld  <= pipe_issue;
            r_p_vld   <= r_rd_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            // load the result payload
            if (out_load_pred) begin
                r_o_kind <= KIND_PRED;
                r_o_pred <= r_pred;
                r_o_err  <= r_err;
                r_o_idx  <= '0;
                r_o_coef <= '0;
                r_o_last <= !r_fend;
            end else if (out_load_coef) begin
                r_o_kind <= KIND_COEF;
                r_o_pred <= '0;
                r_o_err  <= '0;
                r_o_idx  <= IDX_W'(r_cnt) + IDX_W'(1);
                r_o_coef <= neg_sat(r_wrd);
                r_o_last <= (r_cnt == CW'(TAPS - 1));
            end
        end
    end

    // memories: registered read, one write port each
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_wrd <= w_mem[w_raddr];
            r_hrd <= h_mem[h_raddr];
        end
        if (w_we) begin
            w_mem[w_waddr] <= w_wdata;
        end
        if (h_we) begin
            h_mem[h_waddr] <= h_wdata;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_x    <= s_axis_tdata;
            r_fend <= s_axis_tlast;
        end
        if (pipe_issue) begin
            r_addr1 <= r_cnt[IW-1:0];
        end
        if (r_rd_vld) begin
            r_prod  <= mul_p;
            r_wold  <= r_wrd;
            r_addr2 <= r_addr1;
        end
        if (acc_clr) begin
            r_acc <= '0;
        end else if (r_p_vld && r_state == S_PRED) begin
            r_acc <= r_acc + AW'(r_prod);
        end
        if (r_state == S_CALC) begin
            r_pred <= pred_c;
            r_err  <= err_c;
        end
        if (out_load_pred) begin
            r_mu_err <= MU_ERR_W'($signed({1'b0, r_step})) * MU_ERR_W'(r_err);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_o_coef, r_o_idx, r_o_err, r_o_pred};
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;

`ifndef NO_ASSERTIONS
    // no tap work may be in flight while a new sample can be taken
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_rd_vld && !r_p_vld))
        else $error("tap pipeline busy while idle");

    // coefficients are never written during the prediction pass
    a_no_write_in_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRED) |-> !w_we)
        else $error("weight write during prediction");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load_pred || out_load_coef) |-> (!r_out_vld || m_axis_tready))
        else $error("result overwritten");

    // the tap counter stays within the tap range
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TAPS))
        else $error("tap counter out of range");
`endif

endmodule

`default_nettype wire
